// File: rtl/vgt_pkg.sv
// Shared types and constants for the vertical gradient texel generator.
// Used by every module of the block; depends on nothing else.

package vgt_pkg;

   localparam int ROW_W      = 12;
   localparam int CHAN_W     = 8;
   localparam int COLOR_W    = 24;
   localparam int HEIGHT_W   = 13;
   localparam int TEXEL_W    = 32;
   localparam int CSR_DATA_W = 24;
   localparam int CSR_IDX_W  = 2;
   localparam int NUM_CHAN   = 3;
   localparam int WEIGHT_W   = 8;
   localparam int REM_W      = 20;
   localparam int CMP_W      = 21;
   localparam int PROD_W     = 16;
   localparam int SUM_W      = 17;
   localparam int MAX_ROWS   = 4096;

   localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = 8'hFF;
   localparam logic [CHAN_W-1:0]   ALPHA      = 8'hFF;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TOP_COLOR       = 2'd0,
      CSR_BOTTOM_COLOR    = 2'd1,
      CSR_GRADIENT_HEIGHT = 2'd2
   } csr_reg_type;

   typedef struct packed {
      logic [COLOR_W-1:0]  top;
      logic [COLOR_W-1:0]  bottom;
      logic [HEIGHT_W-1:0] divisor;
   } cfg_type;

   typedef struct packed {
      logic                sat;
      logic [WEIGHT_W-1:0] quot;
      logic [REM_W-1:0]    rem;
   } div_type;

endpackage

// File: rtl/vgt_csr.sv
// Configuration registers of the gradient generator.
// Holds both colors and the blend divisor derived from the height; uses vgt_pkg.

module vgt_csr
   import vgt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   output cfg_type               cfg
);

   logic [COLOR_W-1:0]  top_ff, top_in;
   logic [COLOR_W-1:0]  bottom_ff, bottom_in;
   logic [HEIGHT_W-1:0] divisor_ff, divisor_in;
   logic [HEIGHT_W-1:0] height_raw;
   logic [HEIGHT_W-1:0] height_clamped;

   always_comb begin
      top_in     = top_ff;
      bottom_in  = bottom_ff;
      divisor_in = divisor_ff;
      height_raw = csr_write_data[HEIGHT_W-1:0];
      height_clamped = (32'(height_raw) > 32'(MAX_ROWS)) ? HEIGHT_W'(MAX_ROWS) : height_raw;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_TOP_COLOR: begin
               top_in = csr_write_data[COLOR_W-1:0];
            end
            CSR_BOTTOM_COLOR: begin
               bottom_in = csr_write_data[COLOR_W-1:0];
            end
            CSR_GRADIENT_HEIGHT: begin
               divisor_in = (height_clamped > HEIGHT_W'(1)) ?
                            height_clamped - HEIGHT_W'(1) : HEIGHT_W'(1);
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff     <= '0;
         bottom_ff  <= '0;
         divisor_ff <= HEIGHT_W'(1);
      end else begin
         top_ff     <= top_in;
         bottom_ff  <= bottom_in;
         divisor_ff <= divisor_in;
      end
   end

   assign cfg.top     = top_ff;
   assign cfg.bottom  = bottom_ff;
   assign cfg.divisor = divisor_ff;

endmodule

// File: rtl/vgt_div_step.sv
// One pipeline stage of the restoring weight division, two quotient bits per stage.
// Uses the div_type record from vgt_pkg.

module vgt_div_step
   import vgt_pkg::*;
#(
   parameter int HIGH_BIT = 7
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic [HEIGHT_W-1:0] divisor,
   input  logic                up_valid,
   input  div_type             up_data,
   output logic                up_en,
   input  logic                down_en,
   output logic                dn_valid,
   output div_type             dn_data
);

   logic    valid_ff;
   div_type data_ff, data_in;

   always_comb begin
      logic [CMP_W-1:0] shifted;
      data_in = up_data;
      for (int i = 0; i < 2; i++) begin
         shifted = CMP_W'(divisor) << (HIGH_BIT - i);
         if (CMP_W'(data_in.rem) >= shifted) begin
            data_in.rem = REM_W'(CMP_W'(data_in.rem) - shifted);
            data_in.quot[HIGH_BIT - i] = 1'b1;
         end
      end
   end

   assign up_en = !valid_ff || down_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_en) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_en) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

// File: rtl/vgt_blend.sv
// Two-stage color blend: weighted channel products, then the sum divided by 255.
// Holds the result register of the block; uses vgt_pkg.

module vgt_blend
   import vgt_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               up_valid,
   input  div_type            up_data,
   output logic               up_en,
   input  logic               rsp_stall,
   output logic               rsp_valid,
   output logic [TEXEL_W-1:0] rsp_texel_word
);

   logic                                  prod_valid_ff;
   logic [NUM_CHAN-1:0][PROD_W-1:0]       prod_top_ff, prod_top_in;
   logic [NUM_CHAN-1:0][PROD_W-1:0]       prod_bot_ff, prod_bot_in;
   logic                                  out_valid_ff;
   logic [TEXEL_W-1:0]                    texel_ff, texel_in;
   logic                                  prod_en;
   logic                                  out_en;
   logic [WEIGHT_W-1:0]                   weight;

   assign weight = up_data.sat ? WEIGHT_MAX : up_data.quot;

   always_comb begin
      for (int c = 0; c < NUM_CHAN; c++) begin
         prod_top_in[c] = PROD_W'(cfg.top[c*CHAN_W +: CHAN_W]) * PROD_W'(WEIGHT_MAX - weight);
         prod_bot_in[c] = PROD_W'(cfg.bottom[c*CHAN_W +: CHAN_W]) * PROD_W'(weight);
      end
   end

   // The sum stays at or below 255*255, where (x + x/256 + 1) / 256 equals x / 255.
   always_comb begin
      logic [SUM_W-1:0] sum;
      logic [SUM_W-1:0] quot;
      texel_in = '0;
      texel_in[TEXEL_W-1 -: CHAN_W] = ALPHA;
      for (int c = 0; c < NUM_CHAN; c++) begin
         sum  = SUM_W'(prod_top_ff[c]) + SUM_W'(prod_bot_ff[c]);
         quot = (sum + (sum >> CHAN_W) + SUM_W'(1)) >> CHAN_W;
         texel_in[c*CHAN_W +: CHAN_W] = quot[CHAN_W-1:0];
      end
   end

   assign out_en  = !out_valid_ff || !rsp_stall;
   assign prod_en = !prod_valid_ff || out_en;
   assign up_en   = prod_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (prod_en) begin
            prod_valid_ff <= up_valid;
         end
         if (out_en) begin
            out_valid_ff <= prod_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (prod_en) begin
         prod_top_ff <= prod_top_in;
         prod_bot_ff <= prod_bot_in;
      end
      if (out_en) begin
         texel_ff <= texel_in;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_texel_word = texel_ff;

endmodule

// File: rtl/vertical_gradient_texel_generator_unit.sv
// Vertical gradient texel generator: one ARGB texel per row index, one transaction per clock
// unless stalled. Instantiates vgt_csr, vgt_div_step and vgt_blend; uses vgt_pkg.
//
// The block accepts a row index every cycle while the result side does not stall. In the
// pipeline, one stage forms row*255 and detects weight saturation, four stages resolve two
// bits each of the 8-bit blend weight by restoring division against the configured divisor,
// one stage forms the channel products and one stage divides their sums by 255 into the
// result register. Every stage holds its own valid bit, so bubbles are squeezed out while
// the output is stalled and a new transaction may still be taken. Writing the height
// register updates the divisor in the next cycle; there is no clearing pass after reset.

module vertical_gradient_texel_generator_unit
   import vgt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [ROW_W-1:0]      req_row_index,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [TEXEL_W-1:0]    rsp_texel_word,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   localparam int NUM_STEPS = WEIGHT_W / 2;

   cfg_type cfg;
   logic    stage_valid [NUM_STEPS+1];
   div_type stage_data  [NUM_STEPS+1];
   logic    stage_en    [NUM_STEPS+1];

   logic    front_en;
   logic    front_valid_ff;
   div_type front_ff, front_in;

   vgt_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   always_comb begin
      front_in.rem  = REM_W'(req_row_index) * REM_W'(WEIGHT_MAX);
      front_in.quot = '0;
      front_in.sat  = CMP_W'(front_in.rem) >= (CMP_W'(cfg.divisor) << WEIGHT_W);
   end

   assign front_en  = !front_valid_ff || stage_en[0];
   assign req_stall = !front_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else if (front_en) begin
         front_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (front_en) begin
         front_ff <= front_in;
      end
   end

   assign stage_valid[0] = front_valid_ff;
   assign stage_data[0]  = front_ff;

   for (genvar k = 0; k < NUM_STEPS; k++) begin : g_step
      vgt_div_step #(
         .HIGH_BIT (WEIGHT_W - 1 - 2*k)
      ) u_step (
         .clock    (clock),
         .reset    (reset),
         .divisor  (cfg.divisor),
         .up_valid (stage_valid[k]),
         .up_data  (stage_data[k]),
         .up_en    (stage_en[k]),
         .down_en  (stage_en[k+1]),
         .dn_valid (stage_valid[k+1]),
         .dn_data  (stage_data[k+1])
      );
   end

   vgt_blend u_blend (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .up_valid       (stage_valid[NUM_STEPS]),
      .up_data        (stage_data[NUM_STEPS]),
      .up_en          (stage_en[NUM_STEPS]),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_texel_word (rsp_texel_word)
   );

endmodule

// File: rtl/vgt_checker.sv
// Port-level checks for the gradient generator and the bind that attaches them.
// Uses vgt_pkg; observes vertical_gradient_texel_generator_unit.

module vgt_checker
   import vgt_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [TEXEL_W-1:0] rsp_texel_word
);

   // A stalled transaction stays on the result port unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_texel_word))
      else $error("stalled result changed or dropped");

   // Every texel leaves with an opaque alpha byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_texel_word[TEXEL_W-1 -: CHAN_W] == ALPHA)
      else $error("texel alpha is not opaque");

   // With the result side open, the whole pipeline advances and the input is free.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("input stalled while output is open");

   // Reset empties the pipeline.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind vertical_gradient_texel_generator_unit vgt_checker u_vgt_checker (
   .clock          (clock),
   .reset          (reset),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_texel_word (rsp_texel_word)
);
